/* src/pil_pkg.sv */
// ---------------------------------------------------------------------------
// pil_pkg: shared definitions for the positional integer list
// Command codes, field widths, result bundle and default capacity.
// ---------------------------------------------------------------------------
package pil_pkg;

	// default number of list entries
	localparam int CAPACITY_DEF = 64;

	// fixed field widths
	localparam int VAL_W   = 32;
	localparam int POS_W   = 7;
	localparam int CNT_W   = 7;
	localparam int CMD_W   = 2;
	localparam int IN_DW   = 40;
	localparam int OUT_DW  = 48;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

	// position code for "end of list" and "not found"
	localparam logic [POS_W-1:0] POS_END = 7'h7f;

	// one result item
	typedef struct packed {
		logic             err;
		logic [CNT_W-1:0] count;
		logic [VAL_W-1:0] item;
		logic [POS_W-1:0] found;
	} res_t;

endpackage

/* src/pil_ram.sv */
// ---------------------------------------------------------------------------
// pil_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module pil_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* src/pil_ctrl.sv */
// ---------------------------------------------------------------------------
// pil_ctrl: command sequencer for the positional integer list
// Decodes a command, then walks the entry RAM one entry per cycle to shift,
// read or search, and hands one result to the output stage.
// ---------------------------------------------------------------------------
module pil_ctrl #(
	parameter int CAPACITY = pil_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command side
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pil_pkg::CMD_W-1:0]   in_cmd,
	input  logic [pil_pkg::POS_W-1:0]   in_pos,
	input  logic [pil_pkg::VAL_W-1:0]   in_val,
	// result side
	output logic                        res_valid,
	input  logic                        res_ready,
	output pil_pkg::res_t               res,
	// entry ram
	output logic [AW-1:0]               rd_addr,
	input  logic [pil_pkg::VAL_W-1:0]   rd_data,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [pil_pkg::VAL_W-1:0]   wr_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W;

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_UP   = 4'd1;
	localparam logic [3:0] S_UPT  = 4'd2;
	localparam logic [3:0] S_INS  = 4'd3;
	localparam logic [3:0] S_GET  = 4'd4;
	localparam logic [3:0] S_GW   = 4'd5;
	localparam logic [3:0] S_DOWN = 4'd6;
	localparam logic [3:0] S_DNT  = 4'd7;
	localparam logic [3:0] S_FIND = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	// control registers
	logic [3:0]  state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic        wv_q, wv_d;
	logic        cv_q, cv_d;

	// datapath registers
	logic [pil_pkg::CMD_W-1:0] cmd_q, cmd_d;
	logic [pil_pkg::VAL_W-1:0] val_q, val_d;
	logic [AW-1:0]             idx_q, idx_d;
	logic [AW-1:0]             ptr_q, ptr_d;
	logic [AW-1:0]             wa_q, wa_d;
	logic [AW-1:0]             ca_q, ca_d;
	logic                      err_q, err_d;
	logic [pil_pkg::VAL_W-1:0] item_q, item_d;
	logic [pil_pkg::POS_W-1:0] found_q, found_d;

	// command decode
	logic          pos_end;
	logic          pos_bad;
	logic          pos_ge;
	logic          cnt_zero;
	logic          full;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] pos_idx;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;

	assign pos_end  = (in_pos == pil_pkg::POS_END);
	assign pos_bad  = in_pos[pil_pkg::POS_W-1] & ~pos_end;
	assign pos_ext  = PW'(in_pos[pil_pkg::POS_W-2:0]);
	assign cnt_ext  = PW'(cnt_q);
	assign pos_ge   = (pos_ext >= cnt_ext);
	assign cnt_zero = (cnt_q == '0);
	assign full     = (cnt_q == CW'(CAPACITY));
	assign last_idx = AW'(cnt_q - CW'(1));
	assign pos_idx  = AW'(in_pos[pil_pkg::POS_W-2:0]);

	// handshake and result
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.err   = err_q;
	assign res.count = pil_pkg::CNT_W'(cnt_q);
	assign res.item  = item_q;
	assign res.found = found_q;

	// ram ports: value write during insert, else delayed shift write
	assign rd_addr = ptr_q;
	always_comb begin
		if (state_q == S_INS) begin
			wr_en   = 1'b1;
			wr_addr = idx_q;
			wr_data = val_q;
		end else begin
			wr_en   = wv_q;
			wr_addr = wa_q;
			wr_data = rd_data;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		wv_d    = 1'b0;
		cv_d    = 1'b0;
		cmd_d   = cmd_q;
		val_d   = val_q;
		idx_d   = idx_q;
		ptr_d   = ptr_q;
		wa_d    = wa_q;
		ca_d    = ca_q;
		err_d   = err_q;
		item_d  = item_q;
		found_d = found_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d   = in_cmd;
					val_d   = in_val;
					err_d   = 1'b0;
					item_d  = '0;
					found_d = pil_pkg::POS_END;
					state_d = S_FIN;
					if (in_cmd == pil_pkg::CMD_FIND) begin
						if (!cnt_zero) begin
							ptr_d   = '0;
							state_d = S_FIND;
						end
					end else if (pos_bad) begin
						err_d = 1'b1;
					end else if (in_cmd == pil_pkg::CMD_INSERT) begin
						if (full) begin
							err_d = 1'b1;
						end else if (pos_end || pos_ge) begin
							idx_d   = AW'(cnt_q);
							state_d = S_INS;
						end else begin
							idx_d   = pos_idx;
							ptr_d   = last_idx;
							state_d = S_UP;
						end
					end else begin
						if (cnt_zero || (!pos_end && pos_ge)) begin
							err_d = 1'b1;
						end else begin
							idx_d   = pos_end ? last_idx : pos_idx;
							ptr_d   = pos_end ? last_idx : pos_idx;
							state_d = S_GET;
						end
					end
				end
			end
			// shift up: read entry, write it one place higher next cycle
			S_UP: begin
				wv_d = 1'b1;
				wa_d = ptr_q + AW'(1);
				if (ptr_q == idx_q) begin
					state_d = S_UPT;
				end else begin
					ptr_d = ptr_q - AW'(1);
				end
			end
			S_UPT: begin
				state_d = S_INS;
			end
			S_INS: begin
				cnt_d   = cnt_q + CW'(1);
				state_d = S_FIN;
			end
			S_GET: begin
				state_d = S_GW;
			end
			// capture the addressed entry
			S_GW: begin
				item_d = rd_data;
				if (cmd_q == pil_pkg::CMD_PEEK) begin
					state_d = S_FIN;
				end else if (idx_q == last_idx) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_FIN;
				end else begin
					ptr_d   = idx_q + AW'(1);
					state_d = S_DOWN;
				end
			end
			// shift down: read entry, write it one place lower next cycle
			S_DOWN: begin
				wv_d = 1'b1;
				wa_d = ptr_q - AW'(1);
				if (ptr_q == last_idx) begin
					state_d = S_DNT;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_DNT: begin
				cnt_d   = cnt_q - CW'(1);
				state_d = S_FIN;
			end
			// linear search, compare runs in the cycle after the read
			S_FIND: begin
				ptr_d = ptr_q + AW'(1);
				ca_d  = ptr_q;
				cv_d  = 1'b1;
				if (cv_q) begin
					if (rd_data == val_q) begin
						found_d = pil_pkg::POS_W'(ca_q);
						cv_d    = 1'b0;
						state_d = S_FIN;
					end else if (ca_q == last_idx) begin
						cv_d    = 1'b0;
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			wv_q    <= 1'b0;
			cv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			wv_q    <= wv_d;
			cv_q    <= cv_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		val_q   <= val_d;
		idx_q   <= idx_d;
		ptr_q   <= ptr_d;
		wa_q    <= wa_d;
		ca_q    <= ca_d;
		err_q   <= err_d;
		item_q  <= item_d;
		found_q <= found_d;
	end

endmodule

/* src/pil_out.sv */
// ---------------------------------------------------------------------------
// pil_out: result output register
// Holds one result on the master stream so the sequencer can go idle.
// ---------------------------------------------------------------------------
module pil_out (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         res_valid,
	output logic                         res_ready,
	input  pil_pkg::res_t                res,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [pil_pkg::OUT_DW-1:0]   m_tdata,
	output logic [0:0]                   m_tuser
);

	logic          valid_q;
	pil_pkg::res_t data_q;

	// free when empty or when the held transfer completes
	assign res_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	// pack result fields
	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, data_q.found, data_q.item, data_q.count};
	assign m_tuser  = data_q.err;

endmodule

/* src/positional_integer_list.sv */
// ---------------------------------------------------------------------------
// positional_integer_list: ordered list of signed 32-bit integers
// Insert, remove, peek and find on an ordered list held in a RAM.
// ---------------------------------------------------------------------------
// Commands arrive on the slave stream (s_tuser = command, s_tdata = position
// and value); each command gives exactly one result transfer on the master
// stream (m_tuser = error, m_tdata = count, item value, found position).
// One command is worked at a time; s_tready is high only while the
// sequencer is idle. Entries move through one RAM read port and one write
// port, one entry per cycle. An error, or a find on an empty list, goes
// straight to the result register; an append writes the value at the count;
// an insert at p moves the entries from p upward one place up, then writes;
// a remove reads the entry at p, then moves the entries above it one place
// down; a peek only reads; a find compares entries from position 0 upward and
// stops at the first match or the last entry. The next command is taken
// while a finished result waits on a stalled m_tready; a second result
// waits in the sequencer until the output register frees. Reset clears the
// count and the valid flags; the entry RAM is not cleared, since no entry at
// or above the count is used.
// ---------------------------------------------------------------------------
module positional_integer_list #(
	parameter int CAPACITY = pil_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pil_pkg::IN_DW-1:0]   s_tdata,  // position[6:0], value[38:7]
	input  logic [pil_pkg::CMD_W-1:0]   s_tuser,  // cmd[1:0]
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pil_pkg::OUT_DW-1:0]  m_tdata,  // count[6:0], item_value[38:7],
	                                              // found_position[45:39]
	output logic [0:0]                  m_tuser   // error[0]
);

	localparam int AW = $clog2(CAPACITY);

	logic                      res_valid;
	logic                      res_ready;
	pil_pkg::res_t             res;
	logic [AW-1:0]             rd_addr;
	logic [pil_pkg::VAL_W-1:0] rd_data;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [pil_pkg::VAL_W-1:0] wr_data;

	// sequencer
	pil_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_pos    (s_tdata[6:0]),
		.in_val    (s_tdata[38:7]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// entry storage
	pil_ram #(
		.WIDTH (pil_pkg::VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result register
	pil_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* src/pil_chk.sv */
// ---------------------------------------------------------------------------
// pil_chk: port checker for the positional integer list
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
module pil_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [pil_pkg::OUT_DW-1:0] m_tdata,
	input logic [0:0]                 m_tuser
);

	// a stalled result stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its fields
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one command in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while busy");

	// a failed command carries no item and no position
	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[38:7] == '0) &&
			(m_tdata[45:39] == pil_pkg::POS_END))
		else $error("error result with item or position");

	// an item and a found position never come together
	a_item_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[38:7] != '0) |-> (m_tdata[45:39] == pil_pkg::POS_END))
		else $error("item and found position both set");

endmodule

bind positional_integer_list pil_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/positional_integer_list_tb.sv */
// ---------------------------------------------------------------------------
// positional_integer_list_tb: self-checking bench for the positional list
// Drives insert, remove, peek and find commands over the command stream and
// compares every result transfer with a local model of the ordered list or
// a typed row of a directed table that covers the empty list, extreme
// positions and values and the error paths. Random phases grow, shrink and
// churn the list with bursty input, receiver stalls and long output hold-offs.
// ---------------------------------------------------------------------------
module positional_integer_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_CAP     = pil_pkg::CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 300;

	// one row of the directed table
	typedef struct {
		logic [pil_pkg::CMD_W-1:0] cmd;
		logic [pil_pkg::POS_W-1:0] pos;
		logic [pil_pkg::VAL_W-1:0] val;
		bit                        typed;
		pil_pkg::res_t             want;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [pil_pkg::IN_DW-1:0]    s_tdata;  // position[6:0], value[38:7]
	logic [pil_pkg::CMD_W-1:0]    s_tuser;  // cmd[1:0]
	logic                         m_tvalid;
	logic                         m_tready;
	logic [pil_pkg::OUT_DW-1:0]   m_tdata;  // count[6:0], item_value[38:7],
	                                        // found_position[45:39]
	logic [0:0]                   m_tuser;  // error[0]

	// local copy of the list contents
	logic [pil_pkg::VAL_W-1:0] list_mem [0:LIST_CAP-1];
	int                        list_len;

	pil_pkg::res_t pending_results[$];
	dir_row_t      dir_rows[$];
	int            mismatch_cnt;
	int            cmds_sent;
	int            idle_cycles;
	int            holds_done;
	int            hold_left;
	int            rx_mode;
	int            rx_span;
	int            burst_left;

	positional_integer_list uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock, 12 ns period
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// apply one command to the local list and return the result it gives
	function automatic pil_pkg::res_t list_apply(input logic [pil_pkg::CMD_W-1:0] cmd,
		input logic [pil_pkg::POS_W-1:0] pos, input logic [pil_pkg::VAL_W-1:0] val);
		pil_pkg::res_t r;
		int            p;
		int            idx;
		int            hit;
		r.err   = 1'b0;
		r.item  = '0;
		r.found = pil_pkg::POS_END;
		p       = $signed(pos);
		hit     = -1;
		if (cmd == pil_pkg::CMD_FIND) begin
			for (int i = 0; i < list_len; i++)
				if (hit < 0 && list_mem[i] == val)
					hit = i;
			if (hit >= 0)
				r.found = pil_pkg::POS_W'(hit);
		end else if (p < -1) begin
			r.err = 1'b1;
		end else if (cmd == pil_pkg::CMD_INSERT) begin
			if (list_len >= LIST_CAP) begin
				r.err = 1'b1;
			end else begin
				idx = (p == -1 || p >= list_len) ? list_len : p;
				for (int i = list_len; i > idx; i--)
					list_mem[i] = list_mem[i-1];
				list_mem[idx] = val;
				list_len++;
			end
		end else if (list_len == 0 || p >= list_len) begin
			r.err = 1'b1;
		end else begin
			idx    = (p == -1) ? list_len - 1 : p;
			r.item = list_mem[idx];
			if (cmd == pil_pkg::CMD_REMOVE) begin
				for (int i = idx; i + 1 < list_len; i++)
					list_mem[i] = list_mem[i+1];
				list_len--;
			end
		end
		r.count = pil_pkg::CNT_W'(list_len);
		return r;
	endfunction

	function automatic dir_row_t mk_row(input logic [pil_pkg::CMD_W-1:0] cmd,
		input logic [pil_pkg::POS_W-1:0] pos, input logic [pil_pkg::VAL_W-1:0] val,
		input bit typed, input logic err, input logic [pil_pkg::CNT_W-1:0] cnt,
		input logic [pil_pkg::VAL_W-1:0] item, input logic [pil_pkg::POS_W-1:0] found);
		dir_row_t row;
		row.cmd        = cmd;
		row.pos        = pos;
		row.val        = val;
		row.typed      = typed;
		row.want.err   = err;
		row.want.count = cnt;
		row.want.item  = item;
		row.want.found = found;
		return row;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: result mismatch on %s: got %h, expected %h",
			$time, field, got, want);
		mismatch_cnt++;
	endtask

	// offer one command, wait for its transfer, then maybe leave a gap
	task automatic send_cmd(input logic [pil_pkg::CMD_W-1:0] cmd,
		input logic [pil_pkg::POS_W-1:0] pos, input logic [pil_pkg::VAL_W-1:0] val,
		input bit typed, input pil_pkg::res_t want);
		pil_pkg::res_t pred;
		int            gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, val, pos};
		do @(posedge clk); while (!s_tready);
		pred = list_apply(cmd, pos, val);
		pending_results.push_back(typed ? want : pred);
		cmds_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end
		end
	endtask

	// one random command, shaped by the phase mode: 0 grow, 1 shrink, 2 mixed
	task automatic send_random_cmd(input int mode);
		logic [pil_pkg::CMD_W-1:0] cmd;
		logic [pil_pkg::POS_W-1:0] pos;
		logic [pil_pkg::VAL_W-1:0] val;
		pil_pkg::res_t             none;
		int                        c;
		none = '0;
		c    = $urandom_range(0, 99);
		case (mode)
			0: cmd = (c < 70) ? pil_pkg::CMD_INSERT : (c < 80) ? pil_pkg::CMD_REMOVE :
				(c < 90) ? pil_pkg::CMD_PEEK : pil_pkg::CMD_FIND;
			1: cmd = (c < 15) ? pil_pkg::CMD_INSERT : (c < 75) ? pil_pkg::CMD_REMOVE :
				(c < 88) ? pil_pkg::CMD_PEEK : pil_pkg::CMD_FIND;
			default: cmd = (c < 25) ? pil_pkg::CMD_INSERT : (c < 50) ? pil_pkg::CMD_REMOVE :
				(c < 75) ? pil_pkg::CMD_PEEK : pil_pkg::CMD_FIND;
		endcase
		// mostly in-range positions, some end markers and raw codes
		case ($urandom_range(0, 9))
			0:       pos = pil_pkg::POS_W'($urandom);
			1:       pos = pil_pkg::POS_END;
			2:       pos = pil_pkg::POS_W'(list_len);
			default: pos = pil_pkg::POS_W'($urandom_range(0,
				(list_len > 0) ? list_len - 1 : 0));
		endcase
		// values that repeat or already sit in the list give find hits
		case ($urandom_range(0, 3))
			1:       val = pil_pkg::VAL_W'($urandom_range(0, 15));
			2:       val = (list_len > 0) ? list_mem[$urandom_range(0, list_len - 1)]
				: pil_pkg::VAL_W'($urandom);
			default: val = pil_pkg::VAL_W'($urandom);
		endcase
		send_cmd(cmd, pos, val, 1'b0, none);
	endtask

	// result checker
	always @(posedge clk) begin
		pil_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata[31:0], 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[0] !== want.err)
					report_mismatch("error", 32'(m_tuser[0]), 32'(want.err));
				if (m_tdata[6:0] !== want.count)
					report_mismatch("count", 32'(m_tdata[6:0]), 32'(want.count));
				if (m_tdata[38:7] !== want.item)
					report_mismatch("item_value", m_tdata[38:7], want.item);
				if (m_tdata[45:39] !== want.found)
					report_mismatch("found_position", 32'(m_tdata[45:39]),
						32'(want.found));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
			$display("positional_integer_list_tb: FAIL");
			$finish;
		end
	end

	// receiver stall pattern plus two long hold-offs
	initial begin
		m_tready   = 1'b0;
		holds_done = 0;
		hold_left  = 0;
		rx_mode    = 0;
		rx_span    = 0;
		forever begin
			@(negedge clk);
			if (holds_done < 2 && cmds_sent >= ((holds_done == 0) ? 150 : 420)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (rx_span == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_span = $urandom_range(10, 120);
			end else begin
				rx_span--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_span % 8 != 0);
				endcase
			end
		end
	end

	// reset, directed table, random phases, drain
	initial begin
		pil_pkg::res_t none;
		int            mode;
		int            span;
		none         = '0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = pil_pkg::CMD_INSERT;
		list_len     = 0;
		mismatch_cnt = 0;
		cmds_sent    = 0;
		idle_cycles  = 0;
		burst_left   = 0;

		// empty list errors, appends and the edges of position and value
		dir_rows.push_back(mk_row(pil_pkg::CMD_PEEK, pil_pkg::POS_END, 32'd0, 1'b1,
			1'b1, 7'd0, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, 7'd0, 32'd0, 1'b1,
			1'b1, 7'd0, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_FIND, 7'd0, 32'd5, 1'b1,
			1'b0, 7'd0, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_INSERT, 7'h7e, 32'd9, 1'b1,
			1'b1, 7'd0, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_INSERT, 7'd63, 32'h7fffffff, 1'b1,
			1'b0, 7'd1, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_INSERT, pil_pkg::POS_END, 32'h80000000, 1'b1,
			1'b0, 7'd2, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_INSERT, 7'd0, 32'd0, 1'b1,
			1'b0, 7'd3, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_INSERT, 7'd1, 32'hffffffff, 1'b1,
			1'b0, 7'd4, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_PEEK, 7'd0, 32'd0, 1'b1,
			1'b0, 7'd4, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_PEEK, pil_pkg::POS_END, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_FIND, 7'd0, 32'hffffffff, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_FIND, 7'h55, 32'h00012345, 1'b0,
			1'b0, '0, '0, '0));
		// past the count and below the end marker
		dir_rows.push_back(mk_row(pil_pkg::CMD_PEEK, 7'd4, 32'd0, 1'b1,
			1'b1, 7'd4, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, 7'h40, 32'd0, 1'b1,
			1'b1, 7'd4, 32'd0, pil_pkg::POS_END));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, 7'd63, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_INSERT, 7'd2, 32'h55555555, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, 7'd1, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, pil_pkg::POS_END, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_FIND, 7'd0, 32'h7fffffff, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_FIND, 7'd0, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, 7'd0, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_PEEK, 7'd1, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, pil_pkg::POS_END, 32'd0, 1'b0,
			1'b0, '0, '0, '0));
		dir_rows.push_back(mk_row(pil_pkg::CMD_REMOVE, pil_pkg::POS_END, 32'd0, 1'b0,
			1'b0, '0, '0, '0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].cmd, dir_rows[i].pos, dir_rows[i].val,
				dir_rows[i].typed, dir_rows[i].want);

		// first phase fills the list so that inserts hit the full case
		repeat (110) send_random_cmd(0);
		while (cmds_sent < dir_rows.size() + RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 80);
			repeat (span) send_random_cmd(mode);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("positional_integer_list_tb: PASS");
		else
			$display("positional_integer_list_tb: FAIL");
		$finish;
	end

endmodule
